@@ src/tshp_pkg.sv @@
// Shared constants and control structs for the task set hyperperiod block.
// No dependencies; every other design file of the block but tshp_chk imports this package.
package tshp_pkg;

	// Default width of the running major cycle.
	localparam int unsigned LCM_WIDTH_DEF = 32;

	// Fixed field widths of the stream payload.
	localparam int unsigned PERIOD_W = 8;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned MAJOR_W  = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // input beat taken: latch it and start the remainder pass
		logic gcd_load;  // start the GCD on the period and the remainder
		logic quo_load;  // start the division of the period by the GCD
		logic mul_load;  // start the shift-add multiplication
		logic commit;    // update the accumulators and the output register
	} tshp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sat;       // the major cycle of the current set has saturated
		logic div_done;  // the shared divider has finished
		logic gcd_done;  // the GCD has converged
		logic mul_done;  // the multiplication has finished
	} tshp_sts_t;

endpackage

@@ src/tshp_div.sv @@
// Shared restoring divider by an 8-bit divisor, one quotient bit per cycle.
// Depends on tshp_pkg for the field widths.
module tshp_div #(
	parameter int unsigned W = tshp_pkg::LCM_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic                         short_run,  // 8 steps rather than W
	input  logic [W-1:0]                 dividend,
	input  logic [tshp_pkg::PERIOD_W-1:0] divisor,
	output logic                         done,
	output logic [tshp_pkg::PERIOD_W-1:0] rem,
	output logic [tshp_pkg::PERIOD_W-1:0] quo
);
	import tshp_pkg::*;

	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]        num_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] quo_q;
	logic [PERIOD_W-1:0] div_q;
	logic [CW-1:0]       cnt_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;
	logic                fits;

	// One restoring step: bring down the next dividend bit and try a subtraction.
	always_comb begin
		trial = {rem_q, num_q[W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = (trial >= {1'b0, div_q});
	end

	// The step counter is the only control state of the unit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= short_run ? CW'(PERIOD_W) : CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	// Dividend, partial remainder and quotient shift together.
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[W-2:0], 1'b0};
			rem_q <= fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
			quo_q <= {quo_q[PERIOD_W-2:0], fits};
		end
	end

	assign done = (cnt_q == '0);
	assign rem  = rem_q;
	assign quo  = quo_q;

endmodule

@@ src/tshp_dp.sv @@
// Datapath: accumulators, binary GCD, shift-add multiplier and output register.
// Depends on tshp_pkg and instantiates the shared divider tshp_div.
module tshp_dp #(
	parameter int unsigned W = tshp_pkg::LCM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tshp_pkg::tshp_cmd_t           cmd,
	output tshp_pkg::tshp_sts_t           sts,
	input  logic [tshp_pkg::PERIOD_W-1:0] in_period,
	input  logic                          in_new_set,
	output logic [tshp_pkg::MAJOR_W-1:0]  out_major,
	output logic [tshp_pkg::PERIOD_W-1:0] out_minor,
	output logic [tshp_pkg::COUNT_W-1:0]  out_count,
	output logic                          out_ovf
);
	import tshp_pkg::*;

	localparam logic [W-1:0] LIM = {W{1'b1}};
	localparam int unsigned  SH  = W - PERIOD_W;
	localparam int unsigned  PW  = W + PERIOD_W;

	// Accumulators of the current task set.
	logic [W-1:0]        lcm_q;
	logic [PERIOD_W-1:0] min_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic                ovf_q;

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] p_in;
	logic [W-1:0]        a_eff;
	logic [W-1:0]        a_load;

	// GCD and multiplier state.
	logic [PERIOD_W-1:0] x_q;
	logic [PERIOD_W-1:0] y_q;
	logic [2:0]          k_q;
	logic [PERIOD_W-1:0] g;
	logic                gcd_done;
	logic [PERIOD_W-1:0] mq_q;
	logic [PW-1:0]       mcand_q;
	logic [PW-1:0]       prod_q;

	// Divider connections.
	logic                div_load;
	logic [W-1:0]        div_dividend;
	logic [PERIOD_W-1:0] div_divisor;
	logic                div_done;
	logic [PERIOD_W-1:0] div_rem;
	logic [PERIOD_W-1:0] div_quo;

	// Commit values.
	logic                ovf_next;
	logic [W-1:0]        lcm_next;
	logic [PERIOD_W-1:0] min_next;
	logic [COUNT_W-1:0]  cnt_next;

	// A zero period counts as one; a zero accumulator is taken as one too.
	always_comb begin
		p_in   = (in_period == '0) ? PERIOD_W'(1) : in_period;
		a_eff  = (lcm_q == '0) ? W'(1) : lcm_q;
		a_load = in_new_set ? W'(1) : a_eff;
	end

	// The divider first forms the accumulator modulo the period, then period / GCD.
	always_comb begin
		div_load     = cmd.accept | cmd.quo_load;
		div_dividend = cmd.quo_load ? (W'(period_q) << SH) : a_load;
		div_divisor  = cmd.quo_load ? g : p_in;
	end

	tshp_div #(
		.W(W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (div_load),
		.short_run (cmd.quo_load),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.rem       (div_rem),
		.quo       (div_quo)
	);

	// The period of the beat in progress.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			period_q <= p_in;
		end
	end

	// Binary GCD of the period and the remainder, one step a cycle.
	assign gcd_done = (y_q == '0) || (x_q == y_q);
	assign g        = PERIOD_W'(x_q << k_q);

	always_ff @(posedge clk) begin
		if (cmd.gcd_load) begin
			x_q <= period_q;
			y_q <= div_rem;
			k_q <= '0;
		end else if (!gcd_done) begin
			case ({x_q[0], y_q[0]})
				2'b00: begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 3'd1;
				end
				2'b01: begin
					x_q <= x_q >> 1;
				end
				2'b10: begin
					y_q <= y_q >> 1;
				end
				default: begin
					if (x_q > y_q) begin
						x_q <= x_q - y_q;
					end else begin
						y_q <= y_q - x_q;
					end
				end
			endcase
		end
	end

	// Accumulator times (period / GCD), least significant multiplier bit first.
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			mq_q    <= div_quo;
			mcand_q <= PW'(a_eff);
			prod_q  <= '0;
		end else if (mq_q != '0) begin
			if (mq_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
			mq_q    <= mq_q >> 1;
		end
	end

	// New set values; a product with bits above the width saturates the major cycle.
	always_comb begin
		ovf_next = ovf_q | (|prod_q[PW-1:W]);
		lcm_next = ovf_next ? LIM : prod_q[W-1:0];
		min_next = (period_q < min_q) ? period_q : min_q;
		cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_W'(1);
	end

	// Accumulators clear on a new set and update when the result is committed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcm_q <= W'(1);
			min_q <= '1;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.accept && in_new_set) begin
			lcm_q <= W'(1);
			min_q <= '1;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.commit) begin
			lcm_q <= lcm_next;
			min_q <= min_next;
			cnt_q <= cnt_next;
			ovf_q <= ovf_next;
		end
	end

	// Output register holding the result beat.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_major <= MAJOR_W'(lcm_next);
			out_minor <= min_next;
			out_count <= cnt_next;
			out_ovf   <= ovf_next;
		end
	end

	always_comb begin
		sts.sat      = ovf_q;
		sts.div_done = div_done;
		sts.gcd_done = gcd_done;
		sts.mul_done = (mq_q == '0);
	end

endmodule

@@ src/tshp_ctrl.sv @@
// Controller: sequences remainder, GCD, quotient, multiply and commit per beat.
// Depends on tshp_pkg for the command and status structs.
module tshp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output tshp_pkg::tshp_cmd_t cmd,
	input  tshp_pkg::tshp_sts_t sts
);
	import tshp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MOD    = 6'b000010,
		ST_GCD    = 6'b000100,
		ST_QUO    = 6'b001000,
		ST_MUL    = 6'b010000,
		ST_COMMIT = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = ST_MOD;
				end
			end
			ST_MOD: begin
				if (sts.sat) begin
					state_d = ST_COMMIT;
				end else if (sts.div_done) begin
					cmd.gcd_load = 1'b1;
					state_d      = ST_GCD;
				end
			end
			ST_GCD: begin
				if (sts.gcd_done) begin
					cmd.quo_load = 1'b1;
					state_d      = ST_QUO;
				end
			end
			ST_QUO: begin
				if (sts.div_done) begin
					cmd.mul_load = 1'b1;
					state_d      = ST_MUL;
				end
			end
			ST_MUL: begin
				if (sts.mul_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and output beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ src/task_set_hyperperiod_and_min_period.sv @@
// Top level of the task set hyperperiod and minimum period accumulator.
// Depends on tshp_pkg; instantiates tshp_ctrl and tshp_dp.
//
//   Channel  Dir  Handshake          Payload
//   s_*      in   s_tvalid/s_tready  tdata: task_period; tuser: new_set
//   m_*      out  m_tvalid/m_tready  tdata: major_cycle, minor_cycle, task_count;
//                                    tuser: overflowed
//
// One beat at a time, in order: taking the beat, the divider's remainder pass,
// the binary GCD, period / GCD, the shift-add multiply and the commit.
// Once a set has saturated, a beat goes from being taken straight to the commit.
// Reset clears the set to an empty one. A result waiting in the output register
// does not stop the next beat being taken; only its commit waits for the slot.
module task_set_hyperperiod_and_min_period #(
	parameter int unsigned LCM_WIDTH = tshp_pkg::LCM_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] task_period
	input  logic        s_tuser,   // [0] new_set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] major_cycle, [39:32] minor_cycle, [47:40] task_count
	output logic        m_tuser    // [0] overflowed
);
	import tshp_pkg::*;

	tshp_cmd_t           cmd;
	tshp_sts_t           sts;
	logic [MAJOR_W-1:0]  out_major;
	logic [PERIOD_W-1:0] out_minor;
	logic [COUNT_W-1:0]  out_count;

	tshp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tshp_dp #(
		.W(LCM_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_period  (s_tdata),
		.in_new_set (s_tuser),
		.out_major  (out_major),
		.out_minor  (out_minor),
		.out_count  (out_count),
		.out_ovf    (m_tuser)
	);

	// Result beat packed with the first field in the lowest bits.
	assign m_tdata = {out_count, out_minor, out_major};

endmodule

@@ src/tshp_chk.sv @@
// Port-level checker for the task set hyperperiod block, bound to the top level.
// No package dependency; it sees the top level's ports only.
module tshp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	// A waiting input beat keeps its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("waiting input beat changed");

	// A stalled result beat keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

	// The block works on one beat at a time, so it is busy straight after taking one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again while a beat is in progress");

	// Every result counts at least the task just added.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:40] != 8'd0 && m_tdata[39:32] != 8'd0)
		else $error("result with empty task count or zero minor cycle");

	// The major cycle can never be zero.
	a_major: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:0] != 32'd0)
		else $error("result with zero major cycle");

endmodule

bind task_set_hyperperiod_and_min_period tshp_chk u_tshp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ tb/tshp_checker.sv @@
// Checker for the task set hyperperiod block: watches both stream channels,
// predicts each result beat and compares it. Depends on tshp_pkg.
module tshp_checker #(
	parameter int unsigned LCM_WIDTH = tshp_pkg::LCM_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] task_period
	input  logic        s_tuser,   // [0] new_set
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // [31:0] major_cycle, [39:32] minor_cycle, [47:40] task_count
	input  logic        m_tuser,   // [0] overflowed
	output int          fail_count,
	output int          pending
);
	import tshp_pkg::*;

	typedef struct packed {
		logic [MAJOR_W-1:0]  major;
		logic [PERIOD_W-1:0] minor;
		logic [COUNT_W-1:0]  count;
		logic                ovf;
	} cycle_report_t;

	// Reports still owed by the block, oldest first.
	cycle_report_t reports_due[$];

	// Running view of the current task set.
	logic [63:0]         major_run;
	logic [PERIOD_W-1:0] minor_run;
	logic [COUNT_W-1:0]  tasks_run;
	logic                sat_run;

	function automatic logic [63:0] major_limit();
		return (64'd2 << (LCM_WIDTH - 1)) - 64'd1;
	endfunction

	function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		while (b != 64'd0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	task automatic clear_running();
		major_run = 64'd1;
		minor_run = '1;
		tasks_run = '0;
		sat_run   = 1'b0;
	endtask

	// Fold one task into the set and queue the report that it causes.
	task automatic add_task(input logic [7:0] period, input logic fresh);
		logic [63:0]   p;
		logic [63:0]   lim;
		logic [63:0]   base;
		logic [63:0]   g;
		logic [63:0]   q;
		cycle_report_t rep;
		lim = major_limit();
		if (fresh) begin
			clear_running();
		end
		// A zero period counts as a period of one tick.
		p = (period == 8'd0) ? 64'd1 : {56'd0, period};
		if (sat_run) begin
			major_run = lim;
		end else begin
			base = (major_run == 64'd0) ? 64'd1 : major_run;
			g = gcd_of(base, p);
			q = base / g;
			if (q > lim / p) begin
				major_run = lim;
				sat_run   = 1'b1;
			end else begin
				major_run = q * p;
			end
		end
		if (p[7:0] < minor_run) begin
			minor_run = p[7:0];
		end
		if (tasks_run != 8'hFF) begin
			tasks_run = tasks_run + 8'd1;
		end
		rep.major = major_run[31:0];
		rep.minor = minor_run;
		rep.count = tasks_run;
		rep.ovf   = sat_run;
		reports_due.push_back(rep);
	endtask

	task automatic check_field(input string label, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, label, want, got);
			fail_count++;
		end
	endtask

	// Results are matched before new inputs are predicted, so a beat can never
	// be paired with an input taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		cycle_report_t want;
		if (!arst_n) begin
			clear_running();
			reports_due.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got %h/%b",
						$time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = reports_due.pop_front();
					check_field("major_cycle", {32'd0, want.major}, {32'd0, m_tdata[31:0]});
					check_field("minor_cycle", {56'd0, want.minor}, {56'd0, m_tdata[39:32]});
					check_field("task_count", {56'd0, want.count}, {56'd0, m_tdata[47:40]});
					check_field("overflowed", {63'd0, want.ovf}, {63'd0, m_tuser});
				end
			end
			if (s_tvalid && s_tready) begin
				add_task(s_tdata, s_tuser);
			end
			pending <= reports_due.size();
		end
	end

endmodule

@@ tb/tb_task_set_hyperperiod_and_min_period.sv @@
// Testbench top for the task set hyperperiod block: drives task beats and
// result back-pressure, and gives the verdict. Depends on tshp_pkg and tshp_checker.
module tb_task_set_hyperperiod_and_min_period;

	localparam int DIRECTED_N = 19;
	localparam int ITEM_TOTAL = DIRECTED_N + 1600;
	localparam int CALM_TAIL  = 200;
	localparam int HOLD_OFF   = 400;
	localparam int DRAIN      = 150;
	localparam int LIMIT      = 1000000;

	typedef enum logic [1:0] {
		MIX_SMOOTH,
		MIX_FULL,
		MIX_PRIME,
		MIX_EDGE
	} period_mix_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;   // [7:0] task_period
	logic        s_tuser  = 1'b0;   // [0] new_set
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;           // [31:0] major_cycle, [39:32] minor_cycle, [47:40] task_count
	logic        m_tuser;           // [0] overflowed

	int fail_count;
	int pending;
	int sent_count = 0;
	int cycles     = 0;
	bit calm       = 1'b0;
	bit long_done  = 1'b0;

	task_set_hyperperiod_and_min_period dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	tshp_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Free-running clock, period of four units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Pick a period of the requested flavour.
	function automatic logic [7:0] pick_period(period_mix_t mix);
		logic [7:0] v;
		case (mix)
			MIX_SMOOTH: begin
				// Powers of two, optionally times three: the LCM stays small.
				v = 8'd1 << $urandom_range(0, 6);
				if ($urandom_range(0, 1) == 1 && v <= 8'd64) begin
					v = v * 8'd3;
				end
			end
			MIX_PRIME: begin
				case ($urandom_range(0, 7))
					0: v = 8'd131;
					1: v = 8'd163;
					2: v = 8'd197;
					3: v = 8'd211;
					4: v = 8'd229;
					5: v = 8'd239;
					6: v = 8'd241;
					default: v = 8'd251;
				endcase
			end
			MIX_EDGE: begin
				case ($urandom_range(0, 6))
					0: v = 8'd0;
					1: v = 8'd1;
					2: v = 8'd2;
					3: v = 8'd127;
					4: v = 8'd128;
					5: v = 8'd254;
					default: v = 8'd255;
				endcase
			end
			default: begin
				v = 8'($urandom_range(0, 255));
			end
		endcase
		return v;
	endfunction

	// Offer one task beat, wait for it to be taken, then maybe idle a while.
	task automatic send_beat(input logic [7:0] period, input logic fresh);
		s_tvalid <= 1'b1;
		s_tdata  <= period;
		s_tuser  <= fresh;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		sent_count++;
		if (sent_count >= ITEM_TOTAL - CALM_TAIL) begin
			calm = 1'b1;
		end
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// A well-formed task set, with the odd stray new_set when noisy.
	task automatic send_set(input int len, input period_mix_t mix, input bit noisy);
		for (int i = 0; i < len; i++) begin
			send_beat(pick_period(mix), (i == 0) || (noisy && $urandom_range(0, 19) == 0));
		end
	endtask

	// Cycle limit: a hung block ends the run here.
	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Result side: random stall bursts, one long hold-off, then always ready.
	initial begin
		bit pressure_done;
		pressure_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!pressure_done && sent_count >= DIRECTED_N + 100) begin
				pressure_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF - 1) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int roll;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First beat joins the set left by reset, with a zero period.
		send_beat(8'd0, 1'b0);
		send_beat(8'd255, 1'b0);
		send_beat(8'd128, 1'b0);
		send_beat(8'd1, 1'b1);
		send_beat(8'd255, 1'b1);
		send_beat(8'd254, 1'b0);
		// Large primes push the major cycle past 32 bits.
		send_beat(8'd251, 1'b1);
		send_beat(8'd241, 1'b0);
		send_beat(8'd239, 1'b0);
		send_beat(8'd233, 1'b0);
		send_beat(8'd229, 1'b0);
		// Once saturated the major cycle stays put.
		send_beat(8'd2, 1'b0);
		send_beat(8'd0, 1'b0);
		// A new set clears the saturation.
		send_beat(8'd127, 1'b1);
		send_beat(8'd64, 1'b0);
		send_beat(8'h55, 1'b0);
		send_beat(8'hAA, 1'b0);
		send_beat(8'd1, 1'b0);
		send_beat(8'd0, 1'b1);

		// Random task sets, some noise, and one set long enough to hit the count limit.
		while (sent_count < ITEM_TOTAL) begin
			if (!long_done && sent_count >= DIRECTED_N + 700) begin
				long_done = 1'b1;
				send_set(300, MIX_SMOOTH, 1'b0);
			end else begin
				roll = $urandom_range(0, 9);
				if (roll == 0) begin
					send_beat(pick_period(MIX_FULL), 1'($urandom_range(0, 1)));
				end else begin
					send_set($urandom_range(1, 10), period_mix_t'($urandom_range(0, 3)), 1'b1);
				end
			end
		end
		s_tvalid <= 1'b0;

		// Let the last report arrive, then allow for the block's latency.
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
